// ===== sv/cle_pkg.sv =====
// Package for the console line editor: FSM states, key codes, output beat type
// and the prompt table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

    localparam logic [7:0] KEY_CR  = 8'd13;
    localparam logic [7:0] KEY_DEL = 8'h7f;

    localparam logic CHAN_CONSOLE = 1'b0;
    localparam logic CHAN_FORWARD = 1'b1;

    // Carriage return, line feed and "root#".
    localparam int         PROMPT_LEN  = 7;
    localparam logic [2:0] PROMPT_LAST = 3'(PROMPT_LEN - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ECHO,
        ST_PROMPT,
        ST_REPLAY
    } t_state;

    // One output beat on its way to the output register.
    typedef struct packed {
        logic [7:0] data;
        logic       chan;
        logic       last;
    } t_beat;

    function automatic logic [7:0] prompt_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'd13;
            3'd1:    b = 8'd10;
            3'd2:    b = 8'h72;  // r
            3'd3:    b = 8'h6f;  // o
            3'd4:    b = 8'h6f;  // o
            3'd5:    b = 8'h74;  // t
            3'd6:    b = 8'h23;  // #
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cle_line_ram.sv =====
// Line buffer memory of the console line editor: one write port, one read port,
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cle_line_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read data holds while no read is issued, so a stalled beat keeps its byte.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/cle_ctrl.sv =====
// Sequencer of the console line editor: fill count, echo, prompt and line replay.
// Depends on cle_pkg; drives the cle_line_ram ports from the top level.
`timescale 1ns / 1ps
`default_nettype none

module cle_ctrl #(
    parameter int LINE_DEPTH = 32,
    parameter int ADDR_W     = 5,
    parameter int CNT_W      = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_in_byte,
    output logic                   o_beat_valid,
    output cle_pkg::t_beat         o_beat,
    input  wire logic              i_beat_ready,
    output logic                   o_mem_we,
    output logic [ADDR_W-1:0]      o_mem_waddr,
    output logic [7:0]             o_mem_wdata,
    output logic                   o_mem_re,
    output logic [ADDR_W-1:0]      o_mem_raddr,
    input  wire logic [7:0]        i_mem_rdata
);

    import cle_pkg::*;

    t_state            r_state, n_state;
    logic [7:0]        r_byte;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [2:0]        r_pidx, n_pidx;
    logic [ADDR_W-1:0] r_idx, n_idx;

    logic is_cr, is_del, can_append, replay_last, prompt_end;

    always_comb begin
        is_cr       = (r_byte == KEY_CR);
        is_del      = (r_byte == KEY_DEL);
        can_append  = (r_fill < CNT_W'(LINE_DEPTH));
        replay_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_fill);
        prompt_end  = (r_pidx == PROMPT_LAST);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_ECHO;
            end
            ST_ECHO: begin
                if (i_beat_ready) n_state = is_cr ? ST_PROMPT : ST_IDLE;
            end
            ST_PROMPT: begin
                if (i_beat_ready && prompt_end) begin
                    n_state = (r_fill == '0) ? ST_IDLE : ST_REPLAY;
                end
            end
            ST_REPLAY: begin
                if (i_beat_ready && replay_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and memory requests.
    always_comb begin
        o_in_ready   = 1'b0;
        o_beat_valid = 1'b0;
        o_beat       = '{data: r_byte, chan: CHAN_CONSOLE, last: 1'b0};
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_fill[ADDR_W-1:0];
        o_mem_wdata  = r_byte;
        o_mem_re     = 1'b0;
        o_mem_raddr  = r_idx + ADDR_W'(1);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_ECHO: begin
                o_beat_valid = 1'b1;
                o_beat.last  = !is_cr;
                o_mem_we     = i_beat_ready && !is_cr && !is_del && can_append;
            end
            ST_PROMPT: begin
                o_beat_valid = 1'b1;
                o_beat.data  = prompt_byte(r_pidx);
                o_beat.last  = prompt_end && (r_fill == '0);
                // Fetch the first stored byte while the last prompt byte leaves.
                o_mem_re     = i_beat_ready && prompt_end && (r_fill != '0);
                o_mem_raddr  = '0;
            end
            ST_REPLAY: begin
                o_beat_valid = 1'b1;
                o_beat.data  = i_mem_rdata;
                o_beat.chan  = CHAN_FORWARD;
                o_beat.last  = replay_last;
                o_mem_re     = i_beat_ready && !replay_last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Counters.
    always_comb begin
        n_fill = r_fill;
        n_pidx = r_pidx;
        n_idx  = r_idx;
        case (r_state)
            ST_ECHO: begin
                n_pidx = '0;
                n_idx  = '0;
                if (i_beat_ready && !is_cr) begin
                    if (is_del) begin
                        if (r_fill != '0) n_fill = r_fill - CNT_W'(1);
                    end else if (can_append) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                end
            end
            ST_PROMPT: begin
                if (i_beat_ready) begin
                    n_pidx = r_pidx + 3'd1;
                    if (prompt_end) n_fill = (r_fill == '0) ? '0 : r_fill;
                end
            end
            ST_REPLAY: begin
                if (i_beat_ready) begin
                    if (replay_last) n_fill = '0;
                    else             n_idx  = r_idx + ADDR_W'(1);
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pidx  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pidx  <= n_pidx;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_in_byte;
        end
    end

    // The line never holds more than its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(LINE_DEPTH))
        else $error("fill count above line depth");

    // A write and a replay read never share a cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_we && o_mem_re))
        else $error("line memory written and read together");

    // Replay only walks stored entries.
    a_replay_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPLAY) |-> (CNT_W'(r_idx) < r_fill))
        else $error("replay index past the stored line");

    // A finished line leaves the buffer empty.
    a_line_emptied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPLAY && i_beat_ready && replay_last) |=> (r_fill == '0))
        else $error("line not emptied after replay");

endmodule

`default_nettype wire

// ===== sv/console_line_editor_top.sv =====
// Top level of the console line editor: stream ports, output register and the
// wiring of cle_ctrl and cle_line_ram. Depends on cle_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Console line editor.
// The slave stream carries received serial bytes, one byte per beat. For each
// byte the master stream first returns its echo on the console channel
// (tuser = 0). A carriage return then adds CR, LF and the prompt "root#" on the
// console channel, followed by the stored line, oldest byte first, on the
// forward channel (tuser = 1), and empties the line. DEL removes the last
// stored character; any other byte is appended, or dropped when the line holds
// LINE_DEPTH characters. tlast marks the final beat caused by one input byte.
// A byte's beats leave one per cycle while the receiver keeps up; the beat rate
// is set by the single sequencer, which emits one beat per cycle unless stalled
// and reads the line memory one entry ahead of the replayed beat. The next byte
// is taken as soon as the last beat of the previous one sits in the output
// register. When the receiver stalls, the output register holds its beat and
// the sequencer waits with it. Reset clears the fill count and the sequencer;
// the line memory needs no clearing because only entries below the count are
// read.
module console_line_editor_top #(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tuser,   // [0] out_channel
    output logic            o_m_axis_tlast
);

    import cle_pkg::*;

    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);

    logic              beat_valid, beat_ready;
    t_beat             beat;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;

    logic  r_out_valid;
    t_beat r_out;

    // The output register takes a new beat whenever it is empty or being drained.
    assign beat_ready = !r_out_valid || i_m_axis_tready;

    cle_ctrl #(
        .LINE_DEPTH (LINE_DEPTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_in_byte    (i_s_axis_tdata),
        .o_beat_valid (beat_valid),
        .o_beat       (beat),
        .i_beat_ready (beat_ready),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    cle_line_ram #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat_ready) begin
            r_out_valid <= beat_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat_ready && beat_valid) begin
            r_out <= beat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.data;
    assign o_m_axis_tuser  = r_out.chan;
    assign o_m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire
